// File: sv/gnw_pkg.sv
package gnw_pkg;

  localparam int unsigned NumAxes     = 3;
  localparam int unsigned CfgIdxBits  = 2;

  localparam logic [CfgIdxBits-1:0] AxisX = 2'd0;
  localparam logic [CfgIdxBits-1:0] AxisY = 2'd1;
  localparam logic [CfgIdxBits-1:0] AxisZ = 2'd2;

  localparam logic KindNeighbour = 1'b0;
  localparam logic KindBounds    = 1'b1;

  typedef enum logic [1:0] {
    CFG_IDLE,
    CFG_DIVIDE,
    CFG_FINISH
  } cfg_state_e;

endpackage

// File: sv/grid_neighbour_weight_3d_unit.sv
// Channel   Direction  Handshake                Payload
// s_axis    in         tvalid / tready          tdata: coords, tuser: kind
// m_axis    out        tvalid / tready          tdata: low, high, frac per axis
// cfg       in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One beat is accepted per cycle while the output is not stalled and no configuration
// write is busy; each beat passes the one-bit-per-stage divider pipeline in each axis lane.
// Reset clears the pipeline valids and sets every axis to size 1, spacing 1, tile 1.
// A legal configuration write holds cfg_ready and s_axis_tready low through the divide
// and finish states while the tile count and last centre are derived.
// An output stall freezes the whole pipeline; bubbles are not squeezed out.
module grid_neighbour_weight_3d_unit #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       s_axis_tvalid_i,
  output logic                                       s_axis_tready_o,
  // coord_x, coord_y, coord_z, zero fill
  input  logic [((3*COORD_BITS+7)/8)*8-1:0]          s_axis_tdata_i,
  // kind
  input  logic                                       s_axis_tuser_i,
  output logic                                       m_axis_tvalid_o,
  input  logic                                       m_axis_tready_i,
  // low_x, low_y, low_z, high_x, high_y, high_z, frac_x, frac_y, frac_z, zero fill
  output logic [((6*COORD_BITS+3*FRAC_BITS+7)/8)*8-1:0] m_axis_tdata_o,
  input  logic                                       cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  logic [gnw_pkg::CfgIdxBits-1:0]             cfg_index_i,
  input  logic [3*COORD_BITS-1:0]                    cfg_data_i
);
  import gnw_pkg::*;

  localparam int unsigned C     = COORD_BITS;
  localparam int unsigned F     = FRAC_BITS;
  localparam int unsigned Depth = C + F + 1;
  localparam int unsigned OutW  = ((6*C+3*F+7)/8)*8;
  localparam int unsigned OutP  = 6*C + 3*F;

  logic [C-1:0] vol  [NumAxes];
  logic [C-1:0] sp   [NumAxes];
  logic [C-1:0] ts   [NumAxes];
  logic [C-1:0] cnt  [NumAxes];
  logic [C-1:0] last [NumAxes];
  logic [C-1:0] low  [NumAxes];
  logic [C-1:0] high [NumAxes];
  logic [F-1:0] frac [NumAxes];

  logic             adv, take;
  logic [Depth-1:0] vld_q;
  logic             out_vld_q;
  logic [OutP-1:0]  out_q;

  gnw_cfg #(.COORD_BITS(C)) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_valid_i),
    .wr_ready_o (cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .vol_o      (vol),
    .sp_o       (sp),
    .ts_o       (ts),
    .cnt_o      (cnt),
    .last_o     (last)
  );

  assign adv             = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = adv && cfg_ready_o;
  assign take            = s_axis_tvalid_i && s_axis_tready_o;

  for (genvar a = 0; a < NumAxes; a++) begin : g_lane
    gnw_lane #(.COORD_BITS(C), .FRAC_BITS(F)) u_lane (
      .clk_i   (clk_i),
      .en_i    (adv),
      .kind_i  (s_axis_tuser_i),
      .coord_i (s_axis_tdata_i[a*C +: C]),
      .vol_i   (vol[a]),
      .sp_i    (sp[a]),
      .ts_i    (ts[a]),
      .cnt_i   (cnt[a]),
      .last_i  (last[a]),
      .low_o   (low[a]),
      .high_o  (high[a]),
      .frac_o  (frac[a])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[Depth-2:0], take};
      out_vld_q <= vld_q[Depth-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= {frac[2], frac[1], frac[0], high[2], high[1], high[0],
                low[2], low[1], low[0]};
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = OutW'(out_q);

endmodule

// File: sv/gnw_cfg.sv
module gnw_cfg #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              wr_valid_i,
  output logic                              wr_ready_o,
  input  logic [gnw_pkg::CfgIdxBits-1:0]    wr_index_i,
  input  logic [3*COORD_BITS-1:0]           wr_data_i,
  output logic [COORD_BITS-1:0]             vol_o  [gnw_pkg::NumAxes],
  output logic [COORD_BITS-1:0]             sp_o   [gnw_pkg::NumAxes],
  output logic [COORD_BITS-1:0]             ts_o   [gnw_pkg::NumAxes],
  output logic [COORD_BITS-1:0]             cnt_o  [gnw_pkg::NumAxes],
  output logic [COORD_BITS-1:0]             last_o [gnw_pkg::NumAxes]
);
  import gnw_pkg::*;

  localparam int unsigned C = COORD_BITS;
  localparam int unsigned StepBits = $clog2(C);

  cfg_state_e state_q, state_d;

  logic [C-1:0] vol_q  [NumAxes];
  logic [C-1:0] sp_q   [NumAxes];
  logic [C-1:0] ts_q   [NumAxes];
  logic [C-1:0] cnt_q  [NumAxes];
  logic [C-1:0] last_q [NumAxes];

  logic [CfgIdxBits-1:0] axis_q;
  logic [C-1:0]          num_q;
  logic [C-1:0]          rem_q;
  logic [C-1:0]          quo_q;
  logic [StepBits-1:0]   step_q;

  logic [C-1:0]   w_vol, w_sp, w_ts, w_org, w_last;
  logic           accept, legal, step_done;
  logic [C:0]     rem_sh;
  logic           rem_ge;
  logic [C-1:0]   cur_sp, cur_org;
  logic [2*C-1:0] prod;

  assign w_vol  = wr_data_i[C-1:0];
  assign w_sp   = wr_data_i[2*C-1:C];
  assign w_ts   = wr_data_i[3*C-1:2*C];
  assign w_org  = (w_ts - 1'b1) >> 1;
  assign w_last = w_vol - 1'b1;

  assign accept    = wr_valid_i && (state_q == CFG_IDLE);
  assign legal     = (wr_index_i <= AxisZ) && (w_vol != '0) && (w_sp != '0) && w_ts[0];
  assign step_done = (step_q == StepBits'(C - 1));

  assign cur_sp  = sp_q[axis_q];
  assign cur_org = (ts_q[axis_q] - 1'b1) >> 1;
  assign rem_sh  = {rem_q, num_q[C-1]};
  assign rem_ge  = (rem_sh >= {1'b0, cur_sp});
  assign prod    = quo_q * cur_sp;

  always_comb begin
    state_d = state_q;
    case (state_q)
      CFG_IDLE: begin
        if (accept && legal) state_d = CFG_DIVIDE;
      end
      CFG_DIVIDE: begin
        if (step_done) state_d = CFG_FINISH;
      end
      CFG_FINISH: state_d = CFG_IDLE;
      default:    state_d = CFG_IDLE;
    endcase
  end

  always_comb begin
    case (state_q)
      CFG_IDLE: wr_ready_o = 1'b1;
      default:  wr_ready_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CFG_IDLE;
      axis_q  <= AxisX;
      step_q  <= '0;
      for (int a = 0; a < NumAxes; a++) begin
        vol_q[a]  <= C'(1);
        sp_q[a]   <= C'(1);
        ts_q[a]   <= C'(1);
        cnt_q[a]  <= C'(1);
        last_q[a] <= '0;
      end
    end else begin
      state_q <= state_d;
      case (state_q)
        CFG_IDLE: begin
          if (accept && legal) begin
            vol_q[wr_index_i] <= w_vol;
            sp_q[wr_index_i]  <= w_sp;
            ts_q[wr_index_i]  <= w_ts;
            axis_q            <= wr_index_i;
            step_q            <= '0;
          end
        end
        CFG_DIVIDE: step_q <= step_q + 1'b1;
        CFG_FINISH: begin
          cnt_q[axis_q]  <= quo_q + 1'b1;
          last_q[axis_q] <= cur_org + prod[C-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == CFG_IDLE) begin
      num_q <= (w_last >= w_org) ? (w_last - w_org) : '0;
      rem_q <= '0;
      quo_q <= '0;
    end else if (state_q == CFG_DIVIDE) begin
      num_q <= num_q << 1;
      rem_q <= rem_ge ? C'(rem_sh - {1'b0, cur_sp}) : rem_sh[C-1:0];
      quo_q <= {quo_q[C-2:0], rem_ge};
    end
  end

  assign vol_o  = vol_q;
  assign sp_o   = sp_q;
  assign ts_o   = ts_q;
  assign cnt_o  = cnt_q;
  assign last_o = last_q;

endmodule

// File: sv/gnw_lane.sv
module gnw_lane #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic                  kind_i,
  input  logic [COORD_BITS-1:0] coord_i,
  input  logic [COORD_BITS-1:0] vol_i,
  input  logic [COORD_BITS-1:0] sp_i,
  input  logic [COORD_BITS-1:0] ts_i,
  input  logic [COORD_BITS-1:0] cnt_i,
  input  logic [COORD_BITS-1:0] last_i,
  output logic [COORD_BITS-1:0] low_o,
  output logic [COORD_BITS-1:0] high_o,
  output logic [FRAC_BITS-1:0]  frac_o
);
  import gnw_pkg::*;

  localparam int unsigned C = COORD_BITS;
  localparam int unsigned F = FRAC_BITS;
  localparam int unsigned Q = C + F;

  logic [C-1:0]   origin, lastv;
  logic [2*C-1:0] prod;
  logic [2*C:0]   hsum;
  logic           e_div;
  logic [C-1:0]   e_lo, e_hi, e_off;

  assign origin = (ts_i - 1'b1) >> 1;
  assign lastv  = vol_i - 1'b1;
  assign prod   = coord_i * sp_i;
  assign hsum   = {1'b0, prod} + {{(C + 1){1'b0}}, origin} + {{(C + 1){1'b0}}, origin};
  assign e_off  = coord_i - origin;

  always_comb begin
    e_div = 1'b0;
    e_lo  = '0;
    e_hi  = '0;
    if (kind_i == KindNeighbour) begin
      if (coord_i <= origin) begin
        e_lo = '0;
        e_hi = '0;
      end else if (coord_i >= last_i) begin
        e_lo = cnt_i - 1'b1;
        e_hi = cnt_i - 1'b1;
      end else begin
        e_div = 1'b1;
      end
    end else begin
      e_lo = (prod > {{C{1'b0}}, lastv}) ? lastv : prod[C-1:0];
      e_hi = (hsum > {{(C + 1){1'b0}}, lastv}) ? lastv : hsum[C-1:0];
    end
  end

  logic         div_q [Q+1];
  logic [C-1:0] lo_q  [Q+1];
  logic [C-1:0] hi_q  [Q+1];
  logic [C-1:0] rem_q [Q+1];
  logic [Q-1:0] dnd_q [Q+1];
  logic [Q-1:0] quo_q [Q+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q[0] <= e_div;
      lo_q[0]  <= e_lo;
      hi_q[0]  <= e_hi;
      rem_q[0] <= '0;
      dnd_q[0] <= {e_off, {F{1'b0}}};
      quo_q[0] <= '0;
    end
  end

  for (genvar s = 0; s < Q; s++) begin : g_div
    logic [C:0] rsh;
    logic       ge;
    assign rsh = {rem_q[s], dnd_q[s][Q-1]};
    assign ge  = (rsh >= {1'b0, sp_i});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        div_q[s+1] <= div_q[s];
        lo_q[s+1]  <= lo_q[s];
        hi_q[s+1]  <= hi_q[s];
        rem_q[s+1] <= ge ? C'(rsh - {1'b0, sp_i}) : rsh[C-1:0];
        dnd_q[s+1] <= dnd_q[s] << 1;
        quo_q[s+1] <= {quo_q[s][Q-2:0], ge};
      end
    end
  end

  assign low_o  = div_q[Q] ? quo_q[Q][Q-1:F] : lo_q[Q];
  assign high_o = div_q[Q] ? C'(quo_q[Q][Q-1:F] + 1'b1) : hi_q[Q];
  assign frac_o = div_q[Q] ? quo_q[Q][F-1:0] : '0;

endmodule

// File: sim/tb_grid_neighbour_weight_3d_unit.sv
`timescale 1ns / 100ps

module tb_grid_neighbour_weight_3d_unit;
  import gnw_pkg::*;

  localparam int unsigned CB = 16;
  localparam int unsigned FB = 16;
  localparam int unsigned LATENCY = CB + FB + 2;

  typedef struct packed {
    logic [CB-1:0] frac_z, frac_y, frac_x;
    logic [CB-1:0] high_z, high_y, high_x;
    logic [CB-1:0] low_z, low_y, low_x;
  } weights_t;

  typedef struct {
    logic          kind;
    logic [CB-1:0] cx, cy, cz;
    logic          has_fixed;
    weights_t      fixed;
  } query_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [47:0] s_axis_tdata_i = '0;
  logic s_axis_tuser_i = 1'b0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [143:0] m_axis_tdata_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxBits-1:0] cfg_index_i = '0;
  logic [47:0] cfg_data_i = '0;

  grid_neighbour_weight_3d_unit #(.COORD_BITS(CB), .FRAC_BITS(FB)) dut (.*);

  always #5 clk_i = ~clk_i;

  initial begin
    #50_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  logic [63:0] ax_vol[3], ax_sp[3], ax_ts[3], ax_count[3], ax_last[3];
  weights_t expected_weights[$];
  int errors = 0;
  int beats_out = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int kind1_count = 0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic void derive_geometry(int a);
    logic [63:0] origin, last_idx, n;
    origin = (ax_ts[a] - 1) / 2;
    last_idx = ax_vol[a] - 1;
    n = 1;
    if (last_idx >= origin) n = (last_idx - origin) / ax_sp[a] + 1;
    ax_count[a] = n & 16'hffff;
    ax_last[a] = (origin + (n - 1) * ax_sp[a]) & 16'hffff;
  endfunction

  function automatic void apply_setup(logic [CfgIdxBits-1:0] idx, logic [47:0] val);
    if (idx > AxisZ) return;
    if (val[15:0] == 0 || val[31:16] == 0 || val[32] == 1'b0) return;
    ax_vol[idx] = 64'(val[15:0]);
    ax_sp[idx] = 64'(val[31:16]);
    ax_ts[idx] = 64'(val[47:32]);
    derive_geometry(int'(idx));
  endfunction

  function automatic weights_t predict_weights(logic kind, logic [CB-1:0] cx, cy, cz);
    weights_t w;
    logic [CB-1:0] cc[3];
    logic [63:0] c, sp, origin, lastv, lo, hi, fr, off;
    cc[0] = cx;
    cc[1] = cy;
    cc[2] = cz;
    for (int a = 0; a < 3; a++) begin
      c = 64'(cc[a]);
      sp = ax_sp[a];
      origin = (ax_ts[a] - 1) / 2;
      lastv = ax_vol[a] - 1;
      fr = 0;
      if (kind == KindNeighbour) begin
        if (c <= origin) begin
          lo = 0;
          hi = 0;
        end else if (c >= ax_last[a]) begin
          lo = ax_count[a] - 1;
          hi = lo;
        end else begin
          off = c - origin;
          lo = off / sp;
          hi = lo + 1;
          fr = ((off - lo * sp) << FB) / sp;
        end
      end else begin
        lo = c * sp;
        hi = c * sp + 2 * origin;
        if (lo > lastv) lo = lastv;
        if (hi > lastv) hi = lastv;
      end
      case (a)
        0: begin
          w.low_x = lo[15:0]; w.high_x = hi[15:0]; w.frac_x = fr[15:0];
        end
        1: begin
          w.low_y = lo[15:0]; w.high_y = hi[15:0]; w.frac_y = fr[15:0];
        end
        default: begin
          w.low_z = lo[15:0]; w.high_z = hi[15:0]; w.frac_z = fr[15:0];
        end
      endcase
    end
    return w;
  endfunction

  task automatic wait_drained();
    int guard;
    s_axis_tvalid_i <= 1'b0;
    guard = 0;
    while (expected_weights.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_setup(logic [CfgIdxBits-1:0] idx, logic [47:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_setup(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_query(logic kind, logic [CB-1:0] cx, cy, cz,
                            logic has_fixed, weights_t fixed);
    weights_t w;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= kind;
    s_axis_tdata_i <= {cz, cy, cx};
    do @(posedge clk_i); while (!s_axis_tready_o);
    w = has_fixed ? fixed : predict_weights(kind, cx, cy, cz);
    expected_weights.push_back(w);
    if (kind == KindBounds) kind1_count++;
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    weights_t got, want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o;
      beats_out++;
      if (expected_weights.size() == 0) begin
        report($sformatf("unexpected beat %h", got));
      end else begin
        want = expected_weights.pop_front();
        if (got.low_x != want.low_x) report($sformatf("low_x %h vs %h", got.low_x, want.low_x));
        if (got.low_y != want.low_y) report($sformatf("low_y %h vs %h", got.low_y, want.low_y));
        if (got.low_z != want.low_z) report($sformatf("low_z %h vs %h", got.low_z, want.low_z));
        if (got.high_x != want.high_x)
          report($sformatf("high_x %h vs %h", got.high_x, want.high_x));
        if (got.high_y != want.high_y)
          report($sformatf("high_y %h vs %h", got.high_y, want.high_y));
        if (got.high_z != want.high_z)
          report($sformatf("high_z %h vs %h", got.high_z, want.high_z));
        if (got.frac_x != want.frac_x)
          report($sformatf("frac_x %h vs %h", got.frac_x, want.frac_x));
        if (got.frac_y != want.frac_y)
          report($sformatf("frac_y %h vs %h", got.frac_y, want.frac_y));
        if (got.frac_z != want.frac_z)
          report($sformatf("frac_z %h vs %h", got.frac_z, want.frac_z));
      end
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic logic [47:0] random_setup();
    logic [15:0] v, s, t;
    case ($urandom_range(5))
      0: begin
        v = 16'($urandom_range(1, 8));
        s = 16'($urandom_range(1, 4));
        t = 16'($urandom_range(0, 7));
      end
      1: begin
        v = 16'hffff;
        s = 16'($urandom_range(1, 16'hffff));
        t = 16'($urandom);
      end
      2: begin v = 16'($urandom); s = 16'hffff; t = 16'hffff; end
      default: begin
        v = 16'($urandom_range(1, 300));
        s = 16'($urandom_range(1, 64));
        t = 16'($urandom_range(0, 129));
      end
    endcase
    t[0] = 1'b1;
    return {t, s, v};
  endfunction

  function automatic logic [CB-1:0] random_coord(int a, logic kind);
    case ($urandom_range(3))
      0: return CB'($urandom);
      1: return kind ? CB'($urandom_range(0, 20))
                     : CB'($urandom_range(0, 32'(ax_last[a] + 2)));
      default: return kind ? CB'($urandom_range(0, 32'(ax_count[a])))
                           : CB'($urandom_range(0, 32'(ax_vol[a])));
    endcase
  endfunction

  query_row_t plan[$];
  weights_t z, top_bound;

  initial begin
    logic k;
    z = '0;
    for (int a = 0; a < 3; a++) begin
      ax_vol[a] = 1; ax_sp[a] = 1; ax_ts[a] = 1;
      derive_geometry(a);
    end
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset geometry: every axis has a single voxel and a single tile.
    plan.push_back('{KindNeighbour, 16'h0, 16'h0, 16'h0, 1'b1, z});
    plan.push_back('{KindNeighbour, 16'hffff, 16'hffff, 16'hffff, 1'b1, z});
    plan.push_back('{KindBounds, 16'h0, 16'h0, 16'h0, 1'b1, z});
    plan.push_back('{KindBounds, 16'hffff, 16'h1234, 16'hffff, 1'b1, z});
    foreach (plan[i]) send_query(plan[i].kind, plan[i].cx, plan[i].cy, plan[i].cz,
                                 plan[i].has_fixed, plan[i].fixed);
    wait_drained();

    // Rejected writes: zero size, zero spacing, even tile size, unknown index.
    write_setup(AxisX, {16'd5, 16'd4, 16'd0});
    write_setup(AxisY, {16'd5, 16'd0, 16'd9});
    write_setup(AxisZ, {16'd4, 16'd4, 16'd9});
    write_setup(2'd3, {16'd5, 16'd4, 16'd9});
    plan.delete();
    plan.push_back('{KindNeighbour, 16'd3, 16'd3, 16'd3, 1'b1, z});
    foreach (plan[i]) send_query(plan[i].kind, plan[i].cx, plan[i].cy, plan[i].cz,
                                 plan[i].has_fixed, plan[i].fixed);
    wait_drained();

    // x: regular grid, y: volume shorter than the first centre, z: full-range fields.
    write_setup(AxisX, {16'd5, 16'd4, 16'd20});
    write_setup(AxisY, {16'd9, 16'd3, 16'd2});
    write_setup(AxisZ, {16'hffff, 16'hffff, 16'hffff});
    plan.delete();
    plan.push_back('{KindNeighbour, 16'd0, 16'd0, 16'd0, 1'b0, z});
    plan.push_back('{KindNeighbour, 16'd2, 16'd1, 16'd1, 1'b0, z});
    plan.push_back('{KindNeighbour, 16'd3, 16'd3, 16'd2, 1'b0, z});
    plan.push_back('{KindNeighbour, 16'd5, 16'd5, 16'd3, 1'b0, z});
    plan.push_back('{KindNeighbour, 16'd17, 16'd8, 16'h7fff, 1'b0, z});
    plan.push_back('{KindNeighbour, 16'd18, 16'hffff, 16'hfffe, 1'b0, z});
    plan.push_back('{KindNeighbour, 16'hffff, 16'h8000, 16'hffff, 1'b0, z});
    plan.push_back('{KindBounds, 16'd0, 16'd0, 16'd0, 1'b0, z});
    plan.push_back('{KindBounds, 16'd1, 16'd1, 16'd1, 1'b0, z});
    plan.push_back('{KindBounds, 16'd4, 16'd2, 16'd2, 1'b0, z});
    plan.push_back('{KindBounds, 16'd5, 16'd9, 16'h5555, 1'b0, z});
    plan.push_back('{KindBounds, 16'hffff, 16'hffff, 16'haaaa, 1'b0, z});
    foreach (plan[i]) send_query(plan[i].kind, plan[i].cx, plan[i].cy, plan[i].cz,
                                 plan[i].has_fixed, plan[i].fixed);
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 59 : 0;
      recv_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 21 : 0;
      for (int round = 0; round < 6; round++) begin
        write_setup(AxisX, random_setup());
        write_setup(AxisY, random_setup());
        write_setup(AxisZ, random_setup());
        if ($urandom_range(3) == 0)
          write_setup(CfgIdxBits'($urandom_range(3)), 48'($urandom));
        for (int n = 0; n < 97; n++) begin
          k = ($urandom_range(3) == 0);
          send_query(k, random_coord(0, k), random_coord(1, k), random_coord(2, k), 1'b0, z);
          if (n == 50 && round == 2) begin
            s_axis_tvalid_i <= 1'b0;
            while (expected_weights.size() != 0) @(posedge clk_i);
            @(negedge clk_i);
          end
        end
        wait_drained();
      end
    end

    $display("Covered reset geometry, rejected writes, clamped and interior queries,");
    $display("%0d result beats of which %0d were tile-bound queries.", beats_out, kind1_count);
    if (errors == 0 && expected_weights.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/gnw_pkg.sv
sv/gnw_cfg.sv
sv/gnw_lane.sv
sv/grid_neighbour_weight_3d_unit.sv
sim/tb_grid_neighbour_weight_3d_unit.sv
